FILE: sv/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg - shared types and constants for the fit-policy block allocator
// Port widths, register indexes, policy codes and the result bundle.
// ----------------------------------------------------------------------------
package fpba_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_WIDTH_DEF = 16;

  // Fixed port widths
  localparam int BLK_PORT_W  = 4;
  localparam int SIZE_PORT_W = 16;
  localparam int POLICY_W    = 2;
  localparam int COUNT_W     = 5;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_IDX_W   = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;

  // Input actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  typedef enum logic [POLICY_W-1:0] {
    POL_FIRST = 2'd0,
    POL_NEXT  = 2'd1,
    POL_BEST  = 2'd2,
    POL_WORST = 2'd3
  } policy_t;

  // One result word from the sequencer
  typedef struct packed {
    logic                   valid;
    logic                   granted;
    logic [BLK_PORT_W-1:0]  block;
    logic [SIZE_PORT_W-1:0] remaining;
  } res_t;

endpackage

FILE: sv/fit_policy_block_allocator.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator - first/next/best/worst fit block allocator
// Keeps a table of free block sizes and places size requests by policy.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a word is taken on a clock edge with start high and busy low.
//   in_action 0 loads in_size_value into entry in_block_index and returns the
//   next-fit pointer to zero; in_action 1 requests in_size_value.
//   Output: every word gives one result, out_valid high for one cycle with
//   out_granted, out_chosen_block and out_remaining_size. The receiver
//   cannot stall, so results are never held.
//   Config: cfg_we writes cfg_wdata into register cfg_index (0 fit policy,
//   1 block count); write only while idle.
// Timing:
//   Load, or allocate with block count zero: result in the cycle after accept.
//   Allocate: the first read is issued on accept; the scan then reads the
//   entries in use in turn through the table RAM's registered read port,
//   and a write-back state follows a hit. Best/worst fit scan every entry
//   in use, while first/next fit stop at the first hit. A denied request ends after
//   the scan without write-back. busy stays high for the whole scan.
// Reset: clears config to first fit with zero blocks, the pointer to zero.
//   The table is not cleared; entries must be loaded before use.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator #(
  parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_WIDTH = fpba_pkg::SIZE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // command channel
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_action,
  input  logic [fpba_pkg::BLK_PORT_W-1:0]  in_block_index,
  input  logic [fpba_pkg::SIZE_PORT_W-1:0] in_size_value,
  // result channel
  output logic                             out_valid,
  output logic                             out_granted,
  output logic [fpba_pkg::BLK_PORT_W-1:0]  out_chosen_block,
  output logic [fpba_pkg::SIZE_PORT_W-1:0] out_remaining_size,
  // configuration
  input  logic                             cfg_we,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpba_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import fpba_pkg::*;

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  policy_t              policy_r;
  logic [COUNT_W-1:0]   count_r;
  logic [CNT_W-1:0]     act_cnt;

  res_t                 res;
  logic                 out_valid_r;
  logic                 out_granted_r;
  logic [BLK_PORT_W-1:0]  out_block_r;
  logic [SIZE_PORT_W-1:0] out_rem_r;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [SIZE_WIDTH-1:0] ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [SIZE_WIDTH-1:0] ram_rdata;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_FIRST;
      count_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIT_POLICY:  policy_r <= policy_t'(cfg_wdata[POLICY_W-1:0]);
        REG_BLOCK_COUNT: count_r  <= cfg_wdata[COUNT_W-1:0];
        default:         ;
      endcase
    end
  end

  // block count saturates at the table depth
  assign act_cnt = (32'(count_r) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : CNT_W'(count_r);

  fpba_ram #(
    .WIDTH (SIZE_WIDTH),
    .DEPTH (NUM_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fpba_ctrl #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .action      (in_action),
    .block_index (in_block_index),
    .size_value  (in_size_value),
    .policy      (policy_r),
    .act_cnt     (act_cnt),
    .busy        (busy),
    .res         (res),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  // result register: one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_granted_r <= res.granted;
    out_block_r   <= res.block;
    out_rem_r     <= res.remaining;
  end

  assign out_valid          = out_valid_r;
  assign out_granted        = out_granted_r;
  assign out_chosen_block   = out_block_r;
  assign out_remaining_size = out_rem_r;

endmodule

FILE: sv/fpba_ram.sv
// ----------------------------------------------------------------------------
// fpba_ram - generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module fpba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/fpba_ctrl.sv
// ----------------------------------------------------------------------------
// fpba_ctrl - scan sequencer for the fit-policy block allocator
// Streams table entries through one compare unit, keeps the candidate,
// writes back the chosen entry and owns the next-fit pointer.
// ----------------------------------------------------------------------------
module fpba_ctrl #(
  parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_WIDTH = fpba_pkg::SIZE_WIDTH_DEF,
  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1,
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                action,
  input  logic [fpba_pkg::BLK_PORT_W-1:0]     block_index,
  input  logic [fpba_pkg::SIZE_PORT_W-1:0]    size_value,
  input  fpba_pkg::policy_t                   policy,
  input  logic [CNT_W-1:0]                    act_cnt,
  output logic                                busy,
  output fpba_pkg::res_t                      res,
  output logic                                ram_we,
  output logic [IDX_W-1:0]                    ram_waddr,
  output logic [SIZE_WIDTH-1:0]               ram_wdata,
  output logic [IDX_W-1:0]                    ram_raddr,
  input  logic [SIZE_WIDTH-1:0]               ram_rdata
);
  import fpba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_WRITE = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [SIZE_WIDTH-1:0] req_r, req_nxt;
  logic [IDX_W-1:0]      pos_r, pos_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  have_r, have_nxt;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;
  logic [SIZE_WIDTH-1:0] best_val_r, best_val_nxt;
  logic [IDX_W-1:0]      ptr_r, ptr_nxt;

  logic [SIZE_WIDTH-1:0] size_w;
  logic [IDX_W-1:0]      start_pos;
  logic [CNT_W-1:0]      pos_inc;
  logic [IDX_W-1:0]      pos_wrap;
  logic                  fits, better, take, stop_early, last;
  logic [SIZE_WIDTH-1:0] diff;

  assign size_w    = SIZE_WIDTH'(size_value);
  assign start_pos = (policy == POL_NEXT && CNT_W'(ptr_r) < act_cnt) ? ptr_r : '0;

  // wraparound increment over the entries in use
  assign pos_inc  = CNT_W'(pos_r) + CNT_W'(1);
  assign pos_wrap = (pos_inc == act_cnt) ? '0 : IDX_W'(pos_inc);

  // shared compare unit
  assign fits   = (ram_rdata >= req_r);
  assign better = !have_r ||
                  (policy == POL_BEST  && ram_rdata < best_val_r) ||
                  (policy == POL_WORST && ram_rdata > best_val_r);
  assign take       = fits && better;
  assign stop_early = take && (policy == POL_FIRST || policy == POL_NEXT);
  assign last       = ((cnt_r + CNT_W'(1)) == act_cnt);
  assign diff       = best_val_r - req_r;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    pos_nxt      = pos_r;
    cnt_nxt      = cnt_r;
    have_nxt     = have_r;
    best_idx_nxt = best_idx_r;
    best_val_nxt = best_val_r;
    ptr_nxt      = ptr_r;
    ram_we       = 1'b0;
    ram_waddr    = IDX_W'(block_index);
    ram_wdata    = size_w;
    ram_raddr    = start_pos;
    res          = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (action == ACT_LOAD) begin
            res.valid = 1'b1;
            if (32'(block_index) < NUM_BLOCKS) begin
              ram_we        = 1'b1;
              ptr_nxt       = '0;
              res.granted   = 1'b1;
              res.block     = block_index;
              res.remaining = SIZE_PORT_W'(size_w);
            end
          end else if (act_cnt == '0) begin
            // nothing in use: deny at once
            res.valid = 1'b1;
          end else begin
            req_nxt   = size_w;
            pos_nxt   = start_pos;
            cnt_nxt   = '0;
            have_nxt  = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        ram_raddr = pos_wrap;
        if (take) begin
          have_nxt     = 1'b1;
          best_idx_nxt = pos_r;
          best_val_nxt = ram_rdata;
        end
        if (stop_early || (last && (have_r || take))) begin
          state_nxt = S_WRITE;
        end else if (last) begin
          res.valid = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          pos_nxt = pos_wrap;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end

      S_WRITE: begin
        ram_we        = 1'b1;
        ram_waddr     = best_idx_r;
        ram_wdata     = diff;
        res.valid     = 1'b1;
        res.granted   = 1'b1;
        res.block     = BLK_PORT_W'(best_idx_r);
        res.remaining = SIZE_PORT_W'(diff);
        if (policy == POL_NEXT) begin
          ptr_nxt = best_idx_r;
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ptr_r   <= '0;
      have_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      have_r  <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    pos_r      <= pos_nxt;
    cnt_r      <= cnt_nxt;
    best_idx_r <= best_idx_nxt;
    best_val_r <= best_val_nxt;
  end

endmodule
